@@ src/pat_pkg.sv @@
package pat_pkg;

	localparam int TABLE_ENTRIES = 26;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int ADDR_W        = 32;
	localparam int PORT_W        = 16;
	localparam int LEN_W         = 16;
	localparam int USE_W         = 17;
	localparam int TOT_W         = 64;
	localparam int SLOT_W        = 6;
	localparam int LIMIT_W       = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd16384;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
		logic [USE_W-1:0]  uses;
		logic [TOT_W-1:0]  bytes;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic             halve;
		logic [IDX_W-1:0] idx;
		entry_t           data;
	} tbl_wr_t;

endpackage

@@ src/pat_table.sv @@
module pat_table import pat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd,
	input  tbl_wr_t          wr,
	input  logic [CNT_W-1:0] used
);

	entry_t entry_q [TABLE_ENTRIES];

	assign rd = entry_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TABLE_ENTRIES; j++) begin
				entry_q[j] <= '0;
			end
		end else if (wr.en) begin
			for (int j = 0; j < TABLE_ENTRIES; j++) begin
				if (wr.idx == IDX_W'(j)) begin
					entry_q[j].addr  <= wr.data.addr;
					entry_q[j].port  <= wr.data.port;
					entry_q[j].bytes <= wr.data.bytes;
					entry_q[j].uses  <= wr.halve ? (wr.data.uses >> 1) : wr.data.uses;
				end else if (wr.halve && (CNT_W'(j) < used)) begin
					entry_q[j].uses <= entry_q[j].uses >> 1;
				end
			end
		end
	end

endmodule

@@ src/peer_address_tracker.sv @@
// channel  direction  handshake                  payload
// in       input      in_valid / in_ready        peer_ip, peer_port, pkt_bytes
// out      output     out_valid / out_ready      slot, hit, evicted, entry_total,
//                                                untracked_total
// cfg      input      cfg_wr_en                  cfg_wr_data (count_limit)
//
// an input transfer is accepted in idle, scanned entry by entry by the single address
// compare and min-count unit (skipped when empty), then written in the update state
// in_ready is high only while the sequencer is idle; a result waits in the output
// register while the next transfer scans, and the update cycle holds until it is taken
// asynchronous reset clears the table, the fill count and the untracked total
module peer_address_tracker import pat_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ADDR_W-1:0]  peer_ip,
	input  logic [PORT_W-1:0]  peer_port,
	input  logic [LEN_W-1:0]   pkt_bytes,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SLOT_W-1:0]  slot,
	output logic               hit,
	output logic               evicted,
	output logic [TOT_W-1:0]   entry_total,
	output logic [TOT_W-1:0]   untracked_total
);

	state_t             state_q, state_d;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   used_q;
	logic [TOT_W-1:0]   lost_q;
	logic [ADDR_W-1:0]  ip_q;
	logic [PORT_W-1:0]  port_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   slot_q;
	logic [IDX_W-1:0]   min_idx_q;
	logic [USE_W-1:0]   min_uses_q;
	logic               hit_q;
	logic               out_valid_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_hit_q;
	logic               out_evicted_q;
	logic [TOT_W-1:0]   out_total_q;

	logic [IDX_W-1:0] rd_idx;
	entry_t           rd;
	tbl_wr_t          wr;
	logic             full;
	logic             last;
	logic             match;
	logic             new_min;
	logic             fire;
	logic [USE_W-1:0] inc_uses;
	logic [TOT_W-1:0] total_d;
	logic             evict_d;
	logic [TOT_W-1:0] lost_d;

	pat_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr),
		.used   (used_q)
	);

	assign full     = (used_q == CNT_W'(TABLE_ENTRIES));
	assign last     = (idx_q == IDX_W'(used_q - CNT_W'(1)));
	assign match    = (rd.addr == ip_q);
	assign new_min  = (idx_q == '0) || (rd.uses < min_uses_q);
	assign inc_uses = rd.uses + USE_W'(1);
	assign total_d  = hit_q ? (rd.bytes + TOT_W'(len_q)) : TOT_W'(len_q);
	assign evict_d  = !hit_q && full;
	assign lost_d   = evict_d ? (lost_q + rd.bytes) : lost_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		fire     = 1'b0;
		rd_idx   = (state_q == ST_SCAN) ? idx_q : slot_q;
		wr       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (used_q == '0) ? ST_UPDATE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match || last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!out_valid_q || out_ready) begin
					fire    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fire) begin
			wr.en         = 1'b1;
			wr.idx        = slot_q;
			wr.halve      = hit_q && (inc_uses > USE_W'(limit_q));
			wr.data.addr  = ip_q;
			wr.data.port  = port_q;
			wr.data.uses  = hit_q ? inc_uses : '0;
			wr.data.bytes = total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			used_q      <= '0;
			lost_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				lost_q      <= lost_d;
				if (!hit_q && !full) begin
					used_q <= used_q + CNT_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ip_q   <= peer_ip;
					port_q <= peer_port;
					len_q  <= pkt_bytes;
					idx_q  <= '0;
					slot_q <= '0;
					hit_q  <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (match) begin
					hit_q  <= 1'b1;
					slot_q <= idx_q;
				end else begin
					if (new_min) begin
						min_uses_q <= rd.uses;
						min_idx_q  <= idx_q;
					end
					if (last) begin
						if (full) begin
							slot_q <= new_min ? idx_q : min_idx_q;
						end else begin
							slot_q <= IDX_W'(used_q);
						end
					end
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			ST_UPDATE: begin
				if (fire) begin
					out_slot_q    <= SLOT_W'(slot_q);
					out_hit_q     <= hit_q;
					out_evicted_q <= evict_d;
					out_total_q   <= total_d;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign slot            = out_slot_q;
	assign hit             = out_hit_q;
	assign evicted         = out_evicted_q;
	assign entry_total     = out_total_q;
	assign untracked_total = lost_q;

endmodule

@@ src/pat_checker.sv @@
module pat_checker import pat_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [SLOT_W-1:0] slot,
	input logic              hit,
	input logic              evicted,
	input logic [TOT_W-1:0]  entry_total,
	input logic [TOT_W-1:0]  untracked_total
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(entry_total) &&
			$stable(untracked_total))
		else $error("stalled result changed");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted)
		else $error("hit result marked evicted");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> slot < SLOT_W'(TABLE_ENTRIES))
		else $error("slot beyond table");

	// a new entry holds only this transfer's bytes
	a_miss_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> entry_total[TOT_W-1:LEN_W] == '0)
		else $error("new entry total too large");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after transfer");

endmodule

bind peer_address_tracker pat_checker u_pat_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.slot            (slot),
	.hit             (hit),
	.evicted         (evicted),
	.entry_total     (entry_total),
	.untracked_total (untracked_total)
);
